// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with an explicit disable condition
`define HBB_ASSERT_DIS(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// clocked property that is checked in every cycle, reset included
`define HBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hbb_pkg.sv =====
// shared constants, types and the reciprocal table of the horizontal box blur
package hbb_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
  localparam int RADIUS_W    = 4;
  localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
  localparam int IDX_W       = $clog2(WIN_DEPTH);
  localparam int CNT_W       = $clog2(WIN_DEPTH + 1);
  localparam int NUM_CH      = 4;
  localparam int CH_W        = 8;
  localparam int CH_MAX      = (1 << CH_W) - 1;
  localparam int SUM_W       = $clog2(WIN_DEPTH * CH_MAX + 1);
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // channel 0 alpha, 1 red, 2 green, 3 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    sums_t sums;
    logic  row_end;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } q_rd_t;

  typedef enum logic [1:0] {
    F_RUN,
    F_FLUSH,
    F_RESUM
  } front_state_t;

  // floor(2^18 / (2r+1)) + 1; exact quotient for any window sum below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      0:       m = RECIP_W'(262145);
      1:       m = RECIP_W'(87382);
      2:       m = RECIP_W'(52429);
      3:       m = RECIP_W'(37450);
      4:       m = RECIP_W'(29128);
      5:       m = RECIP_W'(23832);
      6:       m = RECIP_W'(20165);
      7:       m = RECIP_W'(17477);
      8:       m = RECIP_W'(15421);
      9:       m = RECIP_W'(13798);
      10:      m = RECIP_W'(12484);
      11:      m = RECIP_W'(11398);
      12:      m = RECIP_W'(10486);
      13:      m = RECIP_W'(9710);
      14:      m = RECIP_W'(9040);
      15:      m = RECIP_W'(8457);
      default: m = RECIP_W'(8457);
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/hbb_in_if.sv =====
// pixel input channel: valid/ready handshake with the incoming pixel
interface hbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_alpha;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_row_end;

  modport source (
    output valid, in_alpha, in_red, in_green, in_blue, in_row_end,
    input  ready
  );

  modport sink (
    input  valid, in_alpha, in_red, in_green, in_blue, in_row_end,
    output ready
  );
endinterface

// ===== rtl/core/hbb_out_if.sv =====
// blurred pixel output channel: valid/ready handshake with the result pixel
interface hbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_row_end;

  modport source (
    output valid, out_alpha, out_red, out_green, out_blue, out_row_end,
    input  ready
  );

  modport sink (
    input  valid, out_alpha, out_red, out_green, out_blue, out_row_end,
    output ready
  );
endinterface

// ===== rtl/core/hbb_fifo.sv =====
// short queue of window sums between the front and the back part
module hbb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  hbb_pkg::q_wr_t wr,
  input  logic           pop,
  output hbb_pkg::q_rd_t rd,
  output logic           space
);
  import hbb_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  // status toward both sides
  assign space    = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign rd.avail = (cnt_r != '0);
  assign rd.item  = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr.push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr.push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!wr.push && pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wr_ptr_r] <= wr.item;
    end
  end

endmodule

// ===== rtl/core/hbb_front.sv =====
// front part: pixel window, running channel sums, row-end flush sequencer, radius-change sum rebuild
module hbb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hbb_pkg::RADIUS_W-1:0]  cfg_wdata,
  hbb_in_if.sink                        in_ch,
  input  logic                          q_space,
  output hbb_pkg::q_wr_t                q_wr,
  output logic [hbb_pkg::RAD_W-1:0]     eff_radius
);
  import hbb_pkg::*;

  front_state_t                        state_r, state_nxt;
  logic [RADIUS_W-1:0]                 cfg_radius_r, cfg_radius_nxt;
  logic [WIN_DEPTH-1:0][NUM_CH-1:0][CH_W-1:0] win_r, win_nxt;
  sums_t                               sum_r, sum_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic [RAD_W-1:0]                    k_r, k_nxt;
  logic [IDX_W-1:0]                    scan_r, scan_nxt;

  logic [RAD_W-1:0] r;
  logic [IDX_W-1:0] two_r;
  logic [IDX_W-1:0] tap_idx;
  pix_t             tap;
  pix_t             pix_in;
  sums_t            sum_acc;
  sums_t            sum_flush;
  sums_t            sum_scan;
  logic [CNT_W-1:0] cnt_inc;
  logic [RAD_W-1:0] owed;
  logic             emit;
  logic             accept;

  // radius clamp
  always_comb begin
    if (int'(cfg_radius_r) > MAX_RADIUS) begin
      r = RAD_W'(MAX_RADIUS);
    end else begin
      r = RAD_W'(cfg_radius_r);
    end
  end

  assign eff_radius = r;
  assign two_r      = IDX_W'(r) << 1;

  // input handshake
  assign in_ch.ready = (state_r == F_RUN) && q_space && !cfg_we;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pix_in      = {in_ch.in_blue, in_ch.in_green, in_ch.in_red, in_ch.in_alpha};

  // single window tap: leaving pixel, flush pixel or resum pixel
  always_comb begin
    unique case (state_r)
      F_RUN:   tap_idx = two_r;
      F_FLUSH: tap_idx = IDX_W'(k_r) + IDX_W'(r) + IDX_W'(1);
      F_RESUM: tap_idx = scan_r;
      default: tap_idx = '0;
    endcase
  end

  assign tap = win_r[tap_idx];

  // per-channel sum updates
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_acc[c]   = sum_r[c] + SUM_W'(pix_in[c]) - SUM_W'(tap[c]);
      sum_flush[c] = sum_r[c] - SUM_W'(tap[c]);
      sum_scan[c]  = sum_r[c] + SUM_W'(tap[c]);
    end
  end

  // row fill level and owed flush count
  always_comb begin
    cnt_inc = (cnt_r == CNT_W'(WIN_DEPTH)) ? cnt_r : cnt_r + CNT_W'(1);
    if (cnt_inc < CNT_W'(r)) begin
      owed = RAD_W'(cnt_inc);
    end else begin
      owed = r;
    end
    emit = (cnt_inc > CNT_W'(r));
  end

  // next state and queue writes
  always_comb begin
    state_nxt      = state_r;
    cfg_radius_nxt = cfg_radius_r;
    win_nxt        = win_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    scan_nxt       = scan_r;
    q_wr.push      = 1'b0;
    q_wr.item.sums = sum_acc;
    q_wr.item.row_end = 1'b0;

    if (cfg_we) begin
      // new radius: rebuild the running sums from the stored window
      cfg_radius_nxt = cfg_wdata;
      state_nxt      = F_RESUM;
      scan_nxt       = '0;
      sum_nxt        = '0;
    end else begin
      unique case (state_r)
        F_RUN: begin
          if (accept) begin
            q_wr.push         = emit;
            q_wr.item.sums    = sum_acc;
            q_wr.item.row_end = in_ch.in_row_end && (owed == '0);
            if (in_ch.in_row_end && (owed == '0)) begin
              win_nxt = '0;
              sum_nxt = '0;
              cnt_nxt = '0;
            end else begin
              win_nxt = {win_r[WIN_DEPTH-2:0], pix_in};
              sum_nxt = sum_acc;
              cnt_nxt = cnt_inc;
              if (in_ch.in_row_end) begin
                k_nxt     = owed - RAD_W'(1);
                state_nxt = F_FLUSH;
              end
            end
          end
        end
        F_FLUSH: begin
          // each step drops the oldest pixel of the shrinking window
          if (q_space) begin
            q_wr.push         = 1'b1;
            q_wr.item.sums    = sum_flush;
            q_wr.item.row_end = (k_r == '0);
            sum_nxt           = sum_flush;
            if (k_r == '0) begin
              win_nxt   = '0;
              sum_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = F_RUN;
            end else begin
              k_nxt = k_r - RAD_W'(1);
            end
          end
        end
        F_RESUM: begin
          sum_nxt = sum_scan;
          if (scan_r == two_r) begin
            state_nxt = F_RUN;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
        default: begin
          state_nxt = F_RUN;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window, sums and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r <= RADIUS_W'(1);
      win_r        <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      scan_r       <= '0;
    end else begin
      cfg_radius_r <= cfg_radius_nxt;
      win_r        <= win_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      k_r          <= k_nxt;
      scan_r       <= scan_nxt;
    end
  end

endmodule

// ===== rtl/core/hbb_back.sv =====
// back part: divide window sums by the window size and hold the result beat
module hbb_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hbb_pkg::q_rd_t            rd,
  input  logic [hbb_pkg::RAD_W-1:0] radius,
  output logic                      pop,
  hbb_out_if.source                 out_ch
);
  import hbb_pkg::*;

  logic [RECIP_W-1:0] recip_m;
  logic [PROD_W-1:0]  prod [NUM_CH];
  pix_t               quot;
  pix_t               pix_r;
  logic               row_end_r;
  logic               out_valid_r, out_valid_nxt;

  // divide by 2r+1 as multiply by reciprocal and shift
  assign recip_m = recip(radius);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(rd.item.sums[c]) * PROD_W'(recip_m);
      quot[c] = prod[c][RECIP_SHIFT +: CH_W];
    end
  end

  // output register handshake
  assign pop = rd.avail && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r     <= quot;
      row_end_r <= rd.item.row_end;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_alpha   = pix_r[0];
  assign out_ch.out_red     = pix_r[1];
  assign out_ch.out_green   = pix_r[2];
  assign out_ch.out_blue    = pix_r[3];
  assign out_ch.out_row_end = row_end_r;

endmodule

// ===== rtl/core/horizontal_box_blur_argb_unit.sv =====
// a blurred pixel passes the queue entry, then the output register, after its window is complete
// throughput: one pixel per cycle inside a row while the queue has space and no radius write
// a row end owing lagged pixels holds off input while the flush emits them
// a radius write holds off input for the write and while the sums are rebuilt from the window
// reset: synchronous, active low; window and sums cleared, radius 1, no output pending
module horizontal_box_blur_argb_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [hbb_pkg::RADIUS_W-1:0] cfg_wdata,
  hbb_in_if.sink                       in_ch,
  hbb_out_if.source                    out_ch
);
  import hbb_pkg::*;

  q_wr_t            q_wr;
  q_rd_t            q_rd;
  logic             q_space;
  logic             q_pop;
  logic [RAD_W-1:0] eff_radius;

  // window and flush sequencing
  hbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_space    (q_space),
    .q_wr       (q_wr),
    .eff_radius (eff_radius)
  );

  // decoupling queue
  hbb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd    (q_rd),
    .space (q_space)
  );

  // division and output beat
  hbb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (q_rd),
    .radius (eff_radius),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/hbb_checker.sv =====
// port-level checks of the horizontal box blur, bound to the top level
`include "assert_macros.svh"

module hbb_checker (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a result beat stays offered until taken
  `HBB_ASSERT_DIS(a_out_hold, !rst_n, out_valid && !out_ready |=> out_valid, "output beat dropped")

  // a radius write starts the sum rebuild, so no pixel is taken next cycle
  `HBB_ASSERT(a_cfg_block, rst_n && cfg_we |=> !in_ready, "pixel taken during sum rebuild")

  // no pixel is taken in the cycle of a radius write
  `HBB_ASSERT_DIS(a_cfg_no_take, !rst_n, cfg_we |-> !(in_valid && in_ready), "pixel on write")

  // reset leaves no result pending
  `HBB_ASSERT(a_rst_clear, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind horizontal_box_blur_argb_unit hbb_checker u_hbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
